// File: sv/rotation_matrix_to_euler_unit_defines.svh
// ----------------------------------------------------------------------------
// rotation matrix to euler unit assertion macros
// concurrent assertion wrappers, removed when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_EULER_UNIT_DEFINES_SVH
`define ROTATION_MATRIX_TO_EULER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle, out of reset
`define RME_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rme assertion failed");

// consequent holds in the cycle after reset is applied
`define RME_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error("rme reset assertion failed");

`else

`define RME_ASSERT_IMPL(lbl, ante, cons)
`define RME_ASSERT_RST(lbl, cons)

`endif

`endif

// File: sv/rme_pkg.sv
// ----------------------------------------------------------------------------
// rme_pkg
// types, constants and cordic helpers shared by the euler angle datapath
// ----------------------------------------------------------------------------
package rme_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int MAX_STAGES    = 24;
  localparam int NUM_STAGES    = (CORDIC_STAGES < MAX_STAGES) ? CORDIC_STAGES : MAX_STAGES;
  localparam int STG_W         = 5;

  localparam int IN_W     = 16;
  localparam int IN_SHIFT = 14;
  localparam int DW       = 34;
  localparam int ZW       = 35;

  localparam int YAW_W   = 17;
  localparam int PITCH_W = 15;
  localparam int ROLL_W  = 16;
  localparam int Q_W     = 20;

  localparam logic signed [Q_W-1:0] YAW_MIN   = -20'sd25736;
  localparam logic signed [Q_W-1:0] YAW_MAX   = 20'sd51471;
  localparam logic signed [Q_W-1:0] PITCH_MIN = -20'sd12868;
  localparam logic signed [Q_W-1:0] PITCH_MAX = 20'sd12868;
  localparam logic signed [Q_W-1:0] ROLL_MIN  = -20'sd25736;
  localparam logic signed [Q_W-1:0] ROLL_MAX  = 20'sd25736;

  localparam logic signed [ZW-1:0] PI_Q30     = 35'sd3373259426;
  localparam logic signed [ZW-1:0] TWO_PI_Q30 = 35'sd6746518852;
  localparam logic [29:0]          INV_GAIN_Q30 = 30'd652032874;
  localparam logic [28:0]          DEG_MUL_Q16  = 29'd480631834;

  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WRAP_YAW,
    CFG_DEG_UNITS
  } cfg_idx_t;

  typedef logic signed [DW-1:0] dat_t;
  typedef logic signed [ZW-1:0] ang_t;
  typedef logic [STG_W-1:0]     stg_t;

  typedef struct packed {
    dat_t x;
    dat_t y;
  } pair_t;

  typedef struct packed {
    dat_t x;
    dat_t y;
    ang_t z;
    logic done;
  } vec_t;

  typedef struct packed {
    vec_t  v;
    pair_t c0;
    pair_t c1;
    dat_t  nz;
  } yaw_t;

  typedef struct packed {
    dat_t px;
    dat_t py;
    dat_t rx;
    dat_t ry;
    ang_t yaw;
  } gain_t;

  typedef struct packed {
    vec_t p;
    vec_t r;
    ang_t yaw;
  } pr_t;

  function automatic ang_t atan_q30(stg_t i);
    ang_t a;
    case (i)
      5'd0:    a = 35'sh3243F6A8;
      5'd1:    a = 35'sh1DAC6705;
      5'd2:    a = 35'sh0FADBAFC;
      5'd3:    a = 35'sh07F56EA6;
      5'd4:    a = 35'sh03FEAB76;
      5'd5:    a = 35'sh01FFD55B;
      5'd6:    a = 35'sh00FFFAAA;
      5'd7:    a = 35'sh007FFF55;
      5'd8:    a = 35'sh003FFFEA;
      5'd9:    a = 35'sh001FFFFD;
      5'd10:   a = 35'sh000FFFFF;
      5'd11:   a = 35'sh0007FFFF;
      5'd12:   a = 35'sh0003FFFF;
      5'd13:   a = 35'sh0001FFFF;
      5'd14:   a = 35'sh0000FFFF;
      5'd15:   a = 35'sh00007FFF;
      5'd16:   a = 35'sh00003FFF;
      5'd17:   a = 35'sh00001FFF;
      5'd18:   a = 35'sh00000FFF;
      5'd19:   a = 35'sh000007FF;
      5'd20:   a = 35'sh000003FF;
      5'd21:   a = 35'sh000001FF;
      5'd22:   a = 35'sh000000FF;
      5'd23:   a = 35'sh0000007F;
      default: a = '0;
    endcase
    return a;
  endfunction

  function automatic dat_t widen_in(logic signed [IN_W-1:0] v);
    dat_t r;
    r = dat_t'(v);
    return r <<< IN_SHIFT;
  endfunction

  // half-plane fold and zero check ahead of the micro-rotations
  function automatic vec_t cordic_start(dat_t x, dat_t y);
    vec_t v;
    logic neg;
    neg    = x[DW-1];
    v.x    = neg ? -x : x;
    v.y    = neg ? -y : y;
    v.z    = neg ? (y[DW-1] ? -PI_Q30 : PI_Q30) : '0;
    v.done = (y == '0);
    return v;
  endfunction

  function automatic pair_t micro_rot(pair_t p, logic up, stg_t i);
    pair_t r;
    dat_t  ax;
    dat_t  ay;
    dat_t  sx;
    dat_t  sy;
    ax  = p.x;
    ay  = p.y;
    sx  = ax >>> i;
    sy  = ay >>> i;
    r.x = up ? ax + sy : ax - sy;
    r.y = up ? ay - sx : ay + sx;
    return r;
  endfunction

  function automatic vec_t cordic_step(vec_t v, stg_t i);
    vec_t  r;
    pair_t p;
    logic  up;
    r   = v;
    up  = !v.y[DW-1];
    p.x = v.x;
    p.y = v.y;
    p   = micro_rot(p, up, i);
    if (!v.done) begin
      r.x = p.x;
      r.y = p.y;
      r.z = up ? v.z + atan_q30(i) : v.z - atan_q30(i);
    end
    return r;
  endfunction

endpackage

// File: sv/rme_yaw_cell.sv
// ----------------------------------------------------------------------------
// rme_yaw_cell
// one yaw cordic stage, rotating both companion columns alongside
// ----------------------------------------------------------------------------
module rme_yaw_cell import rme_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  stg_t stage,
  input  logic in_valid,
  output logic in_ready,
  input  yaw_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output yaw_t out_data
);

  yaw_t data_r, data_nxt;
  logic valid_r;
  logic up;

  always_comb begin
    up       = !in_data.v.y[DW-1];
    data_nxt = in_data;
    data_nxt.v = cordic_step(in_data.v, stage);
    if (!in_data.v.done) begin
      data_nxt.c0 = micro_rot(in_data.c0, up, stage);
      data_nxt.c1 = micro_rot(in_data.c1, up, stage);
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// File: sv/rme_gain.sv
// ----------------------------------------------------------------------------
// rme_gain
// cordic gain removal on the yaw magnitude, yaw wrap, pitch and roll setup
// ----------------------------------------------------------------------------
module rme_gain import rme_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wrap_yaw,
  input  logic  in_valid,
  output logic  in_ready,
  input  yaw_t  in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output gain_t out_data
);

  gain_t data_r, data_nxt;
  logic  valid_r;
  logic [DW+29:0] prod;

  always_comb begin
    prod = (DW+30)'(unsigned'(in_data.v.x)) * (DW+30)'(INV_GAIN_Q30);
    data_nxt.px = in_data.v.done ? in_data.v.x : dat_t'(prod[DW+29:30]);
    data_nxt.py = -in_data.nz;
    data_nxt.rx = in_data.c0.y;
    data_nxt.ry = -in_data.c1.y;
    data_nxt.yaw = (wrap_yaw && in_data.v.z[ZW-1]) ? in_data.v.z + TWO_PI_Q30 : in_data.v.z;
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// File: sv/rme_pr_cell.sv
// ----------------------------------------------------------------------------
// rme_pr_cell
// one stage of the pitch and roll cordics side by side, yaw carried along
// ----------------------------------------------------------------------------
module rme_pr_cell import rme_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  stg_t stage,
  input  logic in_valid,
  output logic in_ready,
  input  pr_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output pr_t  out_data
);

  pr_t  data_r, data_nxt;
  logic valid_r;

  always_comb begin
    data_nxt     = in_data;
    data_nxt.p   = cordic_step(in_data.p, stage);
    data_nxt.r   = cordic_step(in_data.r, stage);
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// File: sv/rme_conv.sv
// ----------------------------------------------------------------------------
// rme_conv
// q30 radians to output units: split product, round, sign and clamp
// ----------------------------------------------------------------------------
module rme_conv import rme_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      deg_units,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  pr_t                       in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [YAW_W-1:0]   out_yaw_angle,
  output logic signed [PITCH_W-1:0] out_pitch_angle,
  output logic signed [ROLL_W-1:0]  out_roll_angle
);

  localparam int NA    = 3;
  localparam int MAG_W = ZW;
  localparam int ML_W  = 17;
  localparam int MH_W  = MAG_W - ML_W;
  localparam int PLO_W = ML_W + 29;
  localparam int PHI_W = MH_W + 29;
  localparam int SUM_W = PHI_W + ML_W;
  localparam int DSH   = 46;
  localparam int RSH   = 17;
  localparam int MQ_W  = MAG_W + 1 - RSH;

  ang_t               zz [NA];
  logic [NA-1:0]      neg_nxt, neg_r;
  logic [MAG_W-1:0]   mag_nxt [NA];
  logic [MAG_W-1:0]   mag_r   [NA];
  logic [PLO_W-1:0]   plo_nxt [NA];
  logic [PLO_W-1:0]   plo_r   [NA];
  logic [PHI_W-1:0]   phi_nxt [NA];
  logic [PHI_W-1:0]   phi_r   [NA];
  logic               valid_a_r;
  logic               ready_a;

  logic [SUM_W-1:0]       dsum [NA];
  logic [MAG_W:0]         rsum [NA];
  logic [MQ_W-1:0]        mq   [NA];
  logic signed [Q_W-1:0]  q    [NA];
  logic signed [Q_W-1:0]  qc   [NA];
  logic signed [Q_W-1:0]  lo   [NA];
  logic signed [Q_W-1:0]  hi   [NA];

  logic                        valid_b_r;
  logic signed [YAW_W-1:0]     yaw_r;
  logic signed [PITCH_W-1:0]   pitch_r;
  logic signed [ROLL_W-1:0]    roll_r;

  // stage a: magnitude and partial products
  always_comb begin
    zz[0] = in_data.yaw;
    zz[1] = in_data.p.z;
    zz[2] = in_data.r.z;
    for (int k = 0; k < NA; k++) begin
      neg_nxt[k] = zz[k][ZW-1];
      mag_nxt[k] = neg_nxt[k] ? unsigned'(-zz[k]) : unsigned'(zz[k]);
      plo_nxt[k] = PLO_W'(mag_nxt[k][ML_W-1:0]) * PLO_W'(DEG_MUL_Q16);
      phi_nxt[k] = PHI_W'(mag_nxt[k][MAG_W-1:ML_W]) * PHI_W'(DEG_MUL_Q16);
    end
  end

  assign ready_a  = !valid_b_r || out_ready;
  assign in_ready = !valid_a_r || ready_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
    end else if (in_ready) begin
      valid_a_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      neg_r <= neg_nxt;
      for (int k = 0; k < NA; k++) begin
        mag_r[k] <= mag_nxt[k];
        plo_r[k] <= plo_nxt[k];
        phi_r[k] <= phi_nxt[k];
      end
    end
  end

  // stage b: rounding, sign, clamp
  always_comb begin
    lo[0] = YAW_MIN;
    hi[0] = YAW_MAX;
    lo[1] = PITCH_MIN;
    hi[1] = PITCH_MAX;
    lo[2] = ROLL_MIN;
    hi[2] = ROLL_MAX;
    for (int k = 0; k < NA; k++) begin
      dsum[k] = {phi_r[k], {ML_W{1'b0}}} + SUM_W'(plo_r[k]) + (SUM_W'(1) << (DSH - 1));
      rsum[k] = (MAG_W+1)'(mag_r[k]) + ((MAG_W+1)'(1) << (RSH - 1));
      mq[k]   = deg_units ? MQ_W'(dsum[k][SUM_W-1:DSH]) : rsum[k][MAG_W:RSH];
      q[k]    = neg_r[k] ? -signed'(Q_W'(mq[k])) : signed'(Q_W'(mq[k]));
      if (q[k] < lo[k]) begin
        qc[k] = lo[k];
      end else if (q[k] > hi[k]) begin
        qc[k] = hi[k];
      end else begin
        qc[k] = q[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_b_r <= 1'b0;
    end else if (ready_a) begin
      valid_b_r <= valid_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && valid_a_r) begin
      yaw_r   <= qc[0][YAW_W-1:0];
      pitch_r <= qc[1][PITCH_W-1:0];
      roll_r  <= qc[2][ROLL_W-1:0];
    end
  end

  assign out_valid       = valid_b_r;
  assign out_yaw_angle   = yaw_r;
  assign out_pitch_angle = pitch_r;
  assign out_roll_angle  = roll_r;

endmodule

// File: sv/rotation_matrix_to_euler_unit.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_unit
// zyx yaw, pitch and roll from seven q1.14 rotation matrix entries
// ----------------------------------------------------------------------------
// The unit takes one matrix item per clock while the output is taken, and
// returns one angle item per item, in order. It is built from a row of
// yaw cordic cells, one gain multiply stage, a row of cells running the pitch
// and roll cordics side by side, and two unit conversion stages ending in the
// output register. Every stage has its own valid bit and takes a new item
// whenever its successor can move, so throughput is one item per cycle while
// the output is taken, and bubbles close up under backpressure.
`include "rotation_matrix_to_euler_unit_defines.svh"

module rotation_matrix_to_euler_unit import rme_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic                      cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [IN_W-1:0]    in_col0_x,
  input  logic signed [IN_W-1:0]    in_col0_y,
  input  logic signed [IN_W-1:0]    in_col0_z,
  input  logic signed [IN_W-1:0]    in_col1_x,
  input  logic signed [IN_W-1:0]    in_col1_y,
  input  logic signed [IN_W-1:0]    in_col2_x,
  input  logic signed [IN_W-1:0]    in_col2_y,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [YAW_W-1:0]   out_yaw_angle,
  output logic signed [PITCH_W-1:0] out_pitch_angle,
  output logic signed [ROLL_W-1:0]  out_roll_angle
);

  logic wrap_yaw_r;
  logic deg_units_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_yaw_r  <= 1'b1;
      deg_units_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WRAP_YAW:  wrap_yaw_r  <= cfg_wdata;
        CFG_DEG_UNITS: deg_units_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // yaw front: fold into the right half plane, columns follow
  dat_t nx, ny, ox, oy, ax, ay;
  yaw_t yaw_head;

  always_comb begin
    nx = widen_in(in_col0_x);
    ny = widen_in(in_col0_y);
    ox = widen_in(in_col1_x);
    oy = widen_in(in_col1_y);
    ax = widen_in(in_col2_x);
    ay = widen_in(in_col2_y);
    yaw_head.v    = cordic_start(nx, ny);
    yaw_head.c0.x = nx[DW-1] ? -ox : ox;
    yaw_head.c0.y = nx[DW-1] ? -oy : oy;
    yaw_head.c1.x = nx[DW-1] ? -ax : ax;
    yaw_head.c1.y = nx[DW-1] ? -ay : ay;
    yaw_head.nz   = widen_in(in_col0_z);
  end

  yaw_t ych [0:NUM_STAGES];
  logic yv  [0:NUM_STAGES];
  logic yr  [0:NUM_STAGES];

  assign ych[0]   = yaw_head;
  assign yv[0]    = in_valid;
  assign in_ready = yr[0];

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_yaw
    rme_yaw_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage     (stg_t'(g)),
      .in_valid  (yv[g]),
      .in_ready  (yr[g]),
      .in_data   (ych[g]),
      .out_valid (yv[g+1]),
      .out_ready (yr[g+1]),
      .out_data  (ych[g+1])
    );
  end

  gain_t gain_data;
  logic  gain_valid;
  logic  gain_ready;

  rme_gain u_gain (
    .clk       (clk),
    .rst_n     (rst_n),
    .wrap_yaw  (wrap_yaw_r),
    .in_valid  (yv[NUM_STAGES]),
    .in_ready  (yr[NUM_STAGES]),
    .in_data   (ych[NUM_STAGES]),
    .out_valid (gain_valid),
    .out_ready (gain_ready),
    .out_data  (gain_data)
  );

  pr_t pr_head;

  always_comb begin
    pr_head.p   = cordic_start(gain_data.px, gain_data.py);
    pr_head.r   = cordic_start(gain_data.rx, gain_data.ry);
    pr_head.yaw = gain_data.yaw;
  end

  pr_t  pch [0:NUM_STAGES];
  logic pv  [0:NUM_STAGES];
  logic pr  [0:NUM_STAGES];

  assign pch[0]     = pr_head;
  assign pv[0]      = gain_valid;
  assign gain_ready = pr[0];

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_pr
    rme_pr_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage     (stg_t'(g)),
      .in_valid  (pv[g]),
      .in_ready  (pr[g]),
      .in_data   (pch[g]),
      .out_valid (pv[g+1]),
      .out_ready (pr[g+1]),
      .out_data  (pch[g+1])
    );
  end

  rme_conv u_conv (
    .clk             (clk),
    .rst_n           (rst_n),
    .deg_units       (deg_units_r),
    .in_valid        (pv[NUM_STAGES]),
    .in_ready        (pr[NUM_STAGES]),
    .in_data         (pch[NUM_STAGES]),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_yaw_angle   (out_yaw_angle),
    .out_pitch_angle (out_pitch_angle),
    .out_roll_angle  (out_roll_angle)
  );

  `RME_ASSERT_RST(a_reset_empty, !out_valid)
  `RME_ASSERT_IMPL(a_ready_path, out_ready, in_ready)
  `RME_ASSERT_IMPL(a_yaw_range, out_valid, (Q_W'(out_yaw_angle) >= YAW_MIN) && (Q_W'(out_yaw_angle) <= YAW_MAX))
  `RME_ASSERT_IMPL(a_pitch_range, out_valid, (Q_W'(out_pitch_angle) >= PITCH_MIN) && (Q_W'(out_pitch_angle) <= PITCH_MAX))

endmodule
